// ===== src/bts_pkg.sv =====
`timescale 1ns / 1ps
package bts_pkg;
  localparam int MaxSide = 256;
  localparam int SideBits = $clog2(MaxSide);
  localparam int AddrBits = 2 * SideBits;
  localparam int FracBits = 16;
  localparam int CfgIdxBits = 3;
  localparam int CfgDataBits = 16;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_MODE = 3'd0,
    REG_WIDTH = 3'd1,
    REG_HEIGHT = 3'd2,
    REG_TILES_U = 3'd3,
    REG_TILES_V = 3'd4
  } reg_idx_t;

  typedef logic [23:0] rgb_t;
  localparam rgb_t LightColor = {8'd255, 8'd238, 8'd201};
  localparam rgb_t DarkColor = {8'd46, 8'd25, 8'd10};

  // One lerp of one channel with round half up; 8x17 multiplies.
  function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                       input logic [FracBits-1:0] t);
    logic [FracBits:0] one_m;
    logic [FracBits+9:0] acc;
    begin
      one_m = (FracBits+1)'(1 << FracBits) - {1'b0, t};
      acc = (FracBits+10)'(a) * (FracBits+10)'(one_m)
            + (FracBits+10)'(b) * (FracBits+10)'(t)
            + (FracBits+10)'(1 << (FracBits-1));
      lerp8 = acc[FracBits+7:FracBits];
    end
  endfunction

  function automatic logic [SideBits:0] eff_side(input logic [8:0] s);
    begin
      if (s == 9'd0) eff_side = (SideBits+1)'(1);
      else if (s > 9'(MaxSide)) eff_side = (SideBits+1)'(MaxSide);
      else eff_side = (SideBits+1)'(s);
    end
  endfunction
endpackage

// ===== src/bilinear_texture_sampler.sv =====
`timescale 1ns / 1ps
// Channel  | handshake          | payload
// in       | in_valid/in_stall  | kind, texel_*, u_coord, v_coord
// out      | out_valid/out_stall| out_red, out_green, out_blue
// cfg      | cfg_we             | cfg_index, cfg_data
//
// One item per cycle while the pipe is not stalled; a sample passes the coordinate multiply,
// texel fetch and row lerp registers, and the column lerp feeds the output register.
// The texel store is four banks split by row and column parity so that the
// four neighbors read in the same cycle; writes take the same pipe, so a sample
// sees every earlier write (reads follow writes in order through the store).
// Reset is synchronous and clears only control and configuration.
// An out stall with out_valid high freezes the whole pipe; in_stall follows it.
module bilinear_texture_sampler (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic kind,
  input  logic [7:0] texel_col,
  input  logic [7:0] texel_row,
  input  logic [7:0] texel_red,
  input  logic [7:0] texel_green,
  input  logic [7:0] texel_blue,
  input  logic signed [31:0] u_coord,
  input  logic signed [31:0] v_coord,
  output logic out_valid,
  input  logic out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  input  logic cfg_we,
  input  logic [bts_pkg::CfgIdxBits-1:0] cfg_index,
  input  logic [bts_pkg::CfgDataBits-1:0] cfg_data
);
  import bts_pkg::*;

  localparam int HB = SideBits - 1;

  logic mode;
  logic [8:0] tex_width, tex_height;
  logic [15:0] tiles_across, tiles_down;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      tex_width <= 9'd256;
      tex_height <= 9'd256;
      tiles_across <= 16'd256;
      tiles_down <= 16'd256;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_MODE: mode <= cfg_data[0];
        REG_WIDTH: tex_width <= cfg_data[8:0];
        REG_HEIGHT: tex_height <= cfg_data[8:0];
        REG_TILES_U: tiles_across <= cfg_data;
        REG_TILES_V: tiles_down <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipe advances whenever the output register is free.
  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;
  logic in_xfer;
  assign in_xfer = in_valid && adv;

  logic [SideBits:0] w_eff, h_eff;
  assign w_eff = eff_side(tex_width);
  assign h_eff = eff_side(tex_height);

  // Stage 1: multiply.
  logic s1_v, s1_kind, s1_mode;
  logic [AddrBits-1:0] s1_waddr;
  rgb_t s1_wdata;
  logic [FracBits+SideBits:0] s1_xf, s1_yf;
  logic s1_pu, s1_pv;
  logic [FracBits:0] one_m_fv;
  logic signed [48:0] pu_prod, pv_prod;
  assign one_m_fv = (FracBits+1)'(1 << FracBits) - {1'b0, v_coord[FracBits-1:0]};
  assign pu_prod = 49'(u_coord) * 49'($signed({1'b0, tiles_across}));
  assign pv_prod = 49'(v_coord) * 49'($signed({1'b0, tiles_down}));

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (adv) s1_v <= in_valid;
    if (adv) begin
      s1_kind <= kind;
      s1_mode <= mode;
      s1_waddr <= {texel_row, texel_col};
      s1_wdata <= {texel_red, texel_green, texel_blue};
      s1_xf <= (FracBits+SideBits+1)'(u_coord[FracBits-1:0])
               * (FracBits+SideBits+1)'(w_eff - 1'b1);
      s1_yf <= (FracBits+SideBits+1)'(one_m_fv) * (FracBits+SideBits+1)'(h_eff - 1'b1);
      s1_pu <= pu_prod[FracBits+8];
      s1_pv <= pv_prod[FracBits+8];
    end
  end

  // Neighbor coordinates, clamped.
  logic [SideBits:0] x0, y0, x1, y1, xm, ym;
  assign xm = w_eff - 1'b1;
  assign ym = h_eff - 1'b1;
  assign x0 = s1_xf[FracBits+SideBits:FracBits];
  assign y0 = s1_yf[FracBits+SideBits:FracBits];
  assign x1 = (x0 + 1'b1 > xm) ? xm : x0 + 1'b1;
  assign y1 = (y0 + 1'b1 > ym) ? ym : y0 + 1'b1;

  // Banks by (row parity, column parity); bank address {row>>1, col>>1}.
  logic [SideBits-1:0] xa, xb, ya, yb;
  assign xa = x0[HB:0];
  assign xb = x1[HB:0];
  assign ya = y0[HB:0];
  assign yb = y1[HB:0];
  logic [HB-1:0] ecol, ocol, erow, orow;
  // even column/row among the two neighbors, odd likewise
  assign ecol = xa[0] ? xb[HB:1] : xa[HB:1];
  assign ocol = xa[0] ? xa[HB:1] : xb[HB:1];
  assign erow = ya[0] ? yb[HB:1] : ya[HB:1];
  assign orow = ya[0] ? ya[HB:1] : yb[HB:1];

  rgb_t bank0 [MaxSide*MaxSide/4];
  rgb_t bank1 [MaxSide*MaxSide/4];
  rgb_t bank2 [MaxSide*MaxSide/4];
  rgb_t bank3 [MaxSide*MaxSide/4];
  rgb_t rd [4];
  logic wr;
  logic [1:0] wb;
  logic [AddrBits-3:0] wa;
  assign wr = adv && s1_v && !s1_kind;
  assign wb = {s1_waddr[SideBits], s1_waddr[0]};
  assign wa = {s1_waddr[AddrBits-1:SideBits+1], s1_waddr[SideBits-1:1]};

  always_ff @(posedge clk) begin
    if (wr && wb == 2'd0) bank0[wa] <= s1_wdata;
    if (wr && wb == 2'd1) bank1[wa] <= s1_wdata;
    if (wr && wb == 2'd2) bank2[wa] <= s1_wdata;
    if (wr && wb == 2'd3) bank3[wa] <= s1_wdata;
    if (adv) begin
      rd[0] <= bank0[{erow, ecol}];
      rd[1] <= bank1[{erow, ocol}];
      rd[2] <= bank2[{orow, ecol}];
      rd[3] <= bank3[{orow, ocol}];
    end
  end

  // Stage 2: fetch.
  logic s2_v, s2_mode, s2_pu, s2_pv, s2_xo, s2_yo, s2_xc, s2_yc;
  logic [FracBits-1:0] s2_tx, s2_ty;
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (adv) s2_v <= s1_v && s1_kind;
    if (adv) begin
      s2_mode <= s1_mode;
      s2_pu <= s1_pu;
      s2_pv <= s1_pv;
      s2_xo <= xa[0];
      s2_yo <= ya[0];
      s2_xc <= (x1 == x0);
      s2_yc <= (y1 == y0);
      s2_tx <= s1_xf[FracBits-1:0];
      s2_ty <= s1_yf[FracBits-1:0];
    end
  end

  // Route banks back to c00/c10/c01/c11; a clamped neighbor repeats its edge texel.
  rgb_t re0, re1, c00, c10, c01, c11;
  rgb_t ro0, ro1;
  always_comb begin
    re0 = s2_xo ? rd[1] : rd[0];
    re1 = s2_xo ? rd[0] : rd[1];
    ro0 = s2_xo ? rd[3] : rd[2];
    ro1 = s2_xo ? rd[2] : rd[3];
    c00 = s2_yo ? ro0 : re0;
    c10 = s2_yo ? ro1 : re1;
    c01 = s2_yo ? re0 : ro0;
    c11 = s2_yo ? re1 : ro1;
    if (s2_xc) begin
      c10 = c00;
      c11 = c01;
    end
    if (s2_yc) begin
      c01 = c00;
      c11 = c10;
    end
  end

  // Stage 3: row lerps.
  logic s3_v, s3_mode, s3_par;
  logic [FracBits-1:0] s3_ty;
  rgb_t s3_top, s3_bot;
  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (adv) s3_v <= s2_v;
    if (adv) begin
      s3_mode <= s2_mode;
      s3_par <= s2_pu ^ s2_pv;
      s3_ty <= s2_ty;
      for (int i = 0; i < 3; i++) begin
        s3_top[8*i +: 8] <= lerp8(c00[8*i +: 8], c10[8*i +: 8], s2_tx);
        s3_bot[8*i +: 8] <= lerp8(c01[8*i +: 8], c11[8*i +: 8], s2_tx);
      end
    end
  end

  // Stage 4: column lerp, or the checker color when mode is set, into the output register.
  rgb_t res;
  always_comb begin
    for (int i = 0; i < 3; i++)
      res[8*i +: 8] = lerp8(s3_top[8*i +: 8], s3_bot[8*i +: 8], s3_ty);
    if (s3_mode) res = s3_par ? DarkColor : LightColor;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= s3_v;
    if (adv) {out_red, out_green, out_blue} <= res;
  end

  ap_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_red))
    else $error("result changed under stall");
  ap_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");
  ap_fill: assert property (@(posedge clk) disable iff (rst)
    in_xfer && kind |=> s1_v && s1_kind)
    else $error("sample lost entering pipe");
  ap_clamp: assert property (@(posedge clk) disable iff (rst)
    s1_v |-> x1 <= xm && y1 <= ym)
    else $error("neighbor beyond edge");
endmodule
